// File: hw/rtl/ilst_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ilst_pkg
// shared widths, operation and status codes and the cell control type
// ----------------------------------------------------------------------------
package ilst_pkg;

   localparam int ILST_CAPACITY = 64;

   localparam int OP_W    = 3;
   localparam int IDX_W   = 8;
   localparam int VALUE_W = 32;
   localparam int STAT_W  = 2;

   localparam logic [OP_W-1:0] OP_READ     = 3'd0;
   localparam logic [OP_W-1:0] OP_INS_HEAD = 3'd1;
   localparam logic [OP_W-1:0] OP_INS_TAIL = 3'd2;
   localparam logic [OP_W-1:0] OP_INS_AT   = 3'd3;
   localparam logic [OP_W-1:0] OP_DELETE   = 3'd4;

   localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
   localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
   localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

   localparam logic [VALUE_W-1:0] NOT_READ = {VALUE_W{1'b1}};

   // broadcast to every cell of the row
   typedef struct packed {
      logic             ins_en;  // open a slot at pos and write the new word
      logic             del_en;  // close the slot at pos
      logic [IDX_W-1:0] pos;     // insert/delete slot, also the read index
   } ilst_ctl_type;

endpackage
`default_nettype wire

// File: hw/rtl/ilst_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ilst_req_if / ilst_rsp_if
// valid/ready channels carrying request and response words
// ----------------------------------------------------------------------------
interface ilst_req_if import ilst_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [OP_W-1:0]           op;
   logic [IDX_W-1:0]          position;
   logic signed [VALUE_W-1:0] item_value;

   modport source (output valid, output op, output position, output item_value,
                   input ready);
   modport sink   (input valid, input op, input position, input item_value,
                   output ready);
endinterface

interface ilst_rsp_if import ilst_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [VALUE_W-1:0] read_value;
   logic [STAT_W-1:0]         status;

   modport source (output valid, output read_value, output status, input ready);
   modport sink   (input valid, input read_value, input status, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/ilst_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ilst_cell
// one slot of the list: shifts up on insert, down on delete, answers reads
// ----------------------------------------------------------------------------
module ilst_cell import ilst_pkg::*; #(
   parameter int INDEX = 0
) (
   input  logic               clock,
   input  ilst_ctl_type       ctl,
   input  logic [VALUE_W-1:0] new_value,
   input  logic [VALUE_W-1:0] prev_value,
   input  logic [VALUE_W-1:0] next_value,
   output logic [VALUE_W-1:0] value,
   output logic [VALUE_W-1:0] read_term
);

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

   logic [VALUE_W-1:0] value_ff;
   logic [VALUE_W-1:0] value_in;

   always_comb begin
      value_in = value_ff;
      if (ctl.ins_en) begin
         if (MY_IDX > ctl.pos) begin
            value_in = prev_value;
         end else if (MY_IDX == ctl.pos) begin
            value_in = new_value;
         end
      end else if (ctl.del_en) begin
         if (MY_IDX >= ctl.pos) begin
            value_in = next_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value     = value_ff;
   assign read_term = (MY_IDX == ctl.pos) ? value_ff : '0;

endmodule
`default_nettype wire

// File: hw/rtl/indexed_list_store_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// indexed_list_store_core
// ordered list of signed words held in a row of shifting cells
// ----------------------------------------------------------------------------
//  channel   dir  handshake          payload
//  req_ch    in   valid/ready        op, position, item_value
//  rsp_ch    out  valid/ready        read_value, status
//
//  one request word per cycle while the output register is free or draining; its response word
//  appears in the output register on the cycle after acceptance
//  every cell shifts in the same cycle, so inserts and deletes cost the same
//  at any position; reads select one cell through an or-tree
//  reset clears the element count and the output valid; cell contents are
//  left alone, they are only read below the count
//  a request is taken while the output register is empty or being drained
// ----------------------------------------------------------------------------
module indexed_list_store_core import ilst_pkg::*; #(
   parameter int CAPACITY = ILST_CAPACITY
) (
   input  logic              clock,
   input  logic              reset,
   ilst_req_if.sink          req_ch,
   ilst_rsp_if.source        rsp_ch
);

   localparam int CNT_W = $clog2(CAPACITY + 1);
   // common width for comparing an index against the count
   localparam int CMP_W = (CNT_W > IDX_W) ? CNT_W : IDX_W;

   // element count and output register
   logic [CNT_W-1:0]   count_ff,      count_in;
   logic               rsp_valid_ff,  rsp_valid_in;
   logic [VALUE_W-1:0] rsp_value_ff,  rsp_value_in;
   logic [STAT_W-1:0]  rsp_status_ff, rsp_status_in;

   logic               accept;
   ilst_ctl_type       ctl;
   logic [CMP_W-1:0]   pos_ext;
   logic [CMP_W-1:0]   cnt_ext;
   logic [CMP_W-1:0]   ins_at;
   logic               is_full;
   logic [VALUE_W-1:0] read_word;

   logic [VALUE_W-1:0] cell_value [CAPACITY];
   logic [VALUE_W-1:0] cell_term  [CAPACITY];

   // accept while the output register is free or emptying this cycle
   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;

   assign pos_ext = CMP_W'(req_ch.position);
   assign cnt_ext = CMP_W'(count_ff);
   assign is_full = (count_ff == CNT_W'(CAPACITY));

   // decode the request, build the cell control and the response word
   always_comb begin
      ins_at        = pos_ext;
      ctl.ins_en    = 1'b0;
      ctl.del_en    = 1'b0;
      ctl.pos       = req_ch.position;
      count_in      = count_ff;
      rsp_value_in  = NOT_READ;
      rsp_status_in = ST_DONE;

      case (req_ch.op)
         OP_READ: begin
            if (pos_ext < cnt_ext) begin
               rsp_value_in = read_word;
            end else begin
               rsp_status_in = ST_RANGE;
            end
         end
         OP_INS_HEAD, OP_INS_TAIL, OP_INS_AT: begin
            if (req_ch.op == OP_INS_HEAD) begin
               ins_at = '0;
            end else if (req_ch.op == OP_INS_TAIL) begin
               ins_at = cnt_ext;
            end
            // range check comes before the full check
            if (ins_at > cnt_ext) begin
               rsp_status_in = ST_RANGE;
            end else if (is_full) begin
               rsp_status_in = ST_FULL;
            end else begin
               // count is below capacity here, so the slot fits the index width
               ctl.ins_en = accept;
               ctl.pos    = ins_at[IDX_W-1:0];
               if (accept) begin
                  count_in = count_ff + CNT_W'(1);
               end
            end
         end
         OP_DELETE: begin
            if (pos_ext < cnt_ext) begin
               ctl.del_en = accept;
               if (accept) begin
                  count_in = count_ff - CNT_W'(1);
               end
            end else begin
               rsp_status_in = ST_RANGE;
            end
         end
         default: begin
            // unknown op: nothing changes, done with the not-read word
         end
      endcase
   end

   // row of cells, each fed by its neighbours
   for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
      logic [VALUE_W-1:0] prev_word;
      logic [VALUE_W-1:0] next_word;

      if (k == 0) begin : g_head
         // the head cell never shifts up
         assign prev_word = req_ch.item_value;
      end else begin : g_body
         assign prev_word = cell_value[k-1];
      end

      if (k == CAPACITY - 1) begin : g_tail
         // the tail slot falls out of the count on delete, contents do not matter
         assign next_word = cell_value[k];
      end else begin : g_inner
         assign next_word = cell_value[k+1];
      end

      ilst_cell #(
         .INDEX (k)
      ) u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .new_value  (req_ch.item_value),
         .prev_value (prev_word),
         .next_value (next_word),
         .value      (cell_value[k]),
         .read_term  (cell_term[k])
      );
   end

   // or-tree over the masked cell outputs: only the addressed cell is non-zero
   always_comb begin
      read_word = '0;
      for (int k = 0; k < CAPACITY; k++) begin
         read_word = read_word | cell_term[k];
      end
   end

   // output register
   always_comb begin
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_value_ff  <= rsp_value_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.read_value = rsp_value_ff;
   assign rsp_ch.status     = rsp_status_ff;

endmodule
`default_nettype wire

// File: hw/rtl/ilst_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ilst_checker
// port-level checks on the list store, bound to the top level
// ----------------------------------------------------------------------------
module ilst_checker import ilst_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [VALUE_W-1:0] rsp_read_value,
   input logic [STAT_W-1:0]  rsp_status
);

   // a stalled response word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_value)
                                  && $stable(rsp_status))
      else $error("response word changed while stalled");

   // every accepted request is answered on the next cycle
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("accepted request gave no response");

   // a refused or dropped request never returns data
   a_err_no_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_DONE |-> rsp_read_value == NOT_READ)
      else $error("error status with data");

   // reset empties the output register
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind indexed_list_store_core ilst_checker u_ilst_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_ch.valid),
   .req_ready      (req_ch.ready),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_read_value (rsp_ch.read_value),
   .rsp_status     (rsp_ch.status)
);
`default_nettype wire
